FILE: hw/rtl/lcg48_pkg.sv
// ----------------------------------------------------------------------------
// lcg48_pkg
// Shared types and constants of the 48-bit linear congruential generator.
// ----------------------------------------------------------------------------
package lcg48_pkg;

    localparam int unsigned XW = 48;  // state and multiplier width
    localparam int unsigned HW = 24;  // half width for partial products
    localparam int unsigned AW = 16;  // addend width
    localparam int unsigned SW = 32;  // short seed width
    localparam int unsigned LZW = 6;  // leading zero count width
    localparam int unsigned DW = 64;  // binary64 width
    localparam int unsigned EW = 11;  // binary64 exponent width

    localparam logic [XW-1:0] RESET_STATE = 48'h1234abcd330e;
    localparam logic [XW-1:0] DEF_MUL     = 48'h0005deece66d;
    localparam logic [AW-1:0] DEF_ADD     = 16'h000b;
    localparam logic [AW-1:0] LOW_WORD    = 16'h330e;

    // exponent of x / 2^48 when the top set bit is bit 47
    localparam logic [EW-1:0] EXP_TOP     = 11'd1022;

    typedef enum logic [2:0] {
        OP_NEXT_INT  = 3'd0,
        OP_NEXT_EXT  = 3'd1,
        OP_SEED_SHRT = 3'd2,
        OP_SEED_FULL = 3'd3,
        OP_LOAD      = 3'd4
    } lcg48_op_t;

    // generator registers: state, multiplier, addend
    typedef struct packed {
        logic [XW-1:0] state;
        logic [XW-1:0] mul;
        logic [AW-1:0] add;
    } lcg48_regs_t;

endpackage

FILE: hw/rtl/lcg48_step.sv
// ----------------------------------------------------------------------------
// lcg48_step
// One generator step: operation decode, truncated 48-bit multiply-add and
// next register values.
// ----------------------------------------------------------------------------
module lcg48_step
    import lcg48_pkg::*;
(
    input  logic [2:0]    operation,
    input  logic [XW-1:0] given_state,
    input  logic [SW-1:0] seed_word,
    input  logic [XW-1:0] multiplier_in,
    input  logic [AW-1:0] addend_in,
    input  lcg48_regs_t   cur,
    output lcg48_regs_t   nxt,
    output logic [XW-1:0] value
);

    logic [XW-1:0] mul_x;
    logic [XW-1:0] prod_lo;
    logic [XW-1:0] prod_m1;
    logic [XW-1:0] prod_m2;
    logic [HW-1:0] cross_sum;
    logic [XW-1:0] stepped;

    // pick the value to advance
    always_comb
    begin
        if (operation == OP_NEXT_EXT)
        begin
            mul_x = given_state;
        end
        else
        begin
            mul_x = cur.state;
        end
    end

    // a*x mod 2^48 from three 24x24 partial products
    assign prod_lo   = {{HW{1'b0}}, cur.mul[HW-1:0]} * {{HW{1'b0}}, mul_x[HW-1:0]};
    assign prod_m1   = {{HW{1'b0}}, cur.mul[HW-1:0]} * {{HW{1'b0}}, mul_x[XW-1:HW]};
    assign prod_m2   = {{HW{1'b0}}, cur.mul[XW-1:HW]} * {{HW{1'b0}}, mul_x[HW-1:0]};
    assign cross_sum = prod_m1[HW-1:0] + prod_m2[HW-1:0];
    assign stepped   = prod_lo + {cross_sum, {HW{1'b0}}} + {{(XW-AW){1'b0}}, cur.add};

    // next registers and result value
    always_comb
    begin
        nxt   = cur;
        value = '0;
        case (operation)
            OP_NEXT_INT:
            begin
                value     = stepped;
                nxt.state = stepped;
            end
            OP_NEXT_EXT:
            begin
                value = stepped;
            end
            OP_SEED_SHRT:
            begin
                nxt.state = {seed_word, LOW_WORD};
                nxt.mul   = DEF_MUL;
                nxt.add   = DEF_ADD;
            end
            OP_SEED_FULL:
            begin
                nxt.state = given_state;
                nxt.mul   = DEF_MUL;
                nxt.add   = DEF_ADD;
            end
            OP_LOAD:
            begin
                nxt.state = given_state;
                nxt.mul   = multiplier_in;
                nxt.add   = addend_in;
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

FILE: hw/rtl/lcg48_lzc.sv
// ----------------------------------------------------------------------------
// lcg48_lzc
// Leading zero count of a 48-bit value; the count is don't-care for zero.
// ----------------------------------------------------------------------------
module lcg48_lzc
    import lcg48_pkg::*;
(
    input  logic [XW-1:0]  value,
    output logic [LZW-1:0] count
);

    // highest set bit wins
    always_comb
    begin
        count = '0;
        for (int i = 0; i < XW; i++)
        begin
            if (value[i])
            begin
                count = LZW'(XW - 1 - i);
            end
        end
    end

endmodule

FILE: hw/rtl/lcg48_pack.sv
// ----------------------------------------------------------------------------
// lcg48_pack
// Normalizes a 48-bit value and packs value / 2^48 as a binary64 pattern.
// ----------------------------------------------------------------------------
module lcg48_pack
    import lcg48_pkg::*;
(
    input  logic [XW-1:0]  value,
    input  logic [LZW-1:0] count,
    output logic [DW-1:0]  double_bits
);

    localparam int unsigned MW = DW - EW - 1;  // mantissa field width

    logic [XW-1:0] norm;
    logic [EW-1:0] expo;

    // shift the leading one up to bit 47 and drop it
    assign norm = value << count;
    assign expo = EXP_TOP - {{(EW-LZW){1'b0}}, count};

    always_comb
    begin
        if (value == '0)
        begin
            double_bits = '0;
        end
        else
        begin
            double_bits = {1'b0, expo, norm[XW-2:0], {(MW-XW+1){1'b0}}};
        end
    end

endmodule

FILE: hw/rtl/lcg48_random_generator.sv
// ----------------------------------------------------------------------------
// lcg48_random_generator
// 48-bit linear congruential generator with four output forms.
// ----------------------------------------------------------------------------
// Takes one beat per cycle unless the output stalls, and returns one result
// beat for each. The pipeline has four registered stages: input, step, leading
// zero count, output; out_valid rises as a beat enters the output stage.
// The generator registers are updated as an item leaves the input stage, so
// back-to-back steps of the internal state chain through the step stage's
// truncated 48-bit multiply-add (three 24x24 partial products and an add) in
// one combinational path, which sets the one-item-per-cycle figure.
module lcg48_random_generator
    import lcg48_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [2:0]           operation,
    input  logic [XW-1:0]        given_state,
    input  logic [SW-1:0]        seed_word,
    input  logic [XW-1:0]        multiplier_in,
    input  logic [AW-1:0]        addend_in,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [XW-1:0]        new_value,
    output logic [XW-1:0]        previous_state,
    output logic [30:0]          unsigned_31,
    output logic signed [31:0]   signed_32,
    output logic [XW-1:0]        fraction_q48,
    output logic [DW-1:0]        double_bits
);

    // stage valid bits
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic out_valid_reg;

    // stage readiness
    logic out_free;
    logic s3_free;
    logic s2_free;
    logic s1_move;

    // input stage payload
    logic [2:0]    op_reg;
    logic [XW-1:0] given_reg;
    logic [SW-1:0] seed_reg;
    logic [XW-1:0] mul_in_reg;
    logic [AW-1:0] add_in_reg;

    // generator registers
    lcg48_regs_t   gen_reg;
    lcg48_regs_t   gen_next;
    logic [XW-1:0] step_value;

    // later stage payload
    logic [XW-1:0]  s2_value_reg;
    logic [XW-1:0]  s2_prev_reg;
    logic [XW-1:0]  s3_value_reg;
    logic [XW-1:0]  s3_prev_reg;
    logic [LZW-1:0] lz_next;
    logic [LZW-1:0] s3_lz_reg;
    logic [DW-1:0]  dbl_next;
    logic [XW-1:0]  out_value_reg;
    logic [XW-1:0]  out_prev_reg;
    logic [DW-1:0]  out_dbl_reg;

    // ready chain from the output back
    assign out_free = !out_valid_reg || out_ready;
    assign s3_free  = !s3_valid_reg || out_free;
    assign s2_free  = !s2_valid_reg || s3_free;
    assign in_ready = !s1_valid_reg || s2_free;
    assign s1_move  = s1_valid_reg && s2_free;

    lcg48_step u_step (
        .operation     (op_reg),
        .given_state   (given_reg),
        .seed_word     (seed_reg),
        .multiplier_in (mul_in_reg),
        .addend_in     (add_in_reg),
        .cur           (gen_reg),
        .nxt           (gen_next),
        .value         (step_value)
    );

    lcg48_lzc u_lzc (
        .value (s2_value_reg),
        .count (lz_next)
    );

    lcg48_pack u_pack (
        .value       (s3_value_reg),
        .count       (s3_lz_reg),
        .double_bits (dbl_next)
    );

    // valid bits and generator registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            gen_reg.state <= RESET_STATE;
            gen_reg.mul   <= DEF_MUL;
            gen_reg.add   <= DEF_ADD;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_free)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= s3_valid_reg;
            end
            if (s1_move)
            begin
                gen_reg <= gen_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            op_reg     <= operation;
            given_reg  <= given_state;
            seed_reg   <= seed_word;
            mul_in_reg <= multiplier_in;
            add_in_reg <= addend_in;
        end
        if (s1_move)
        begin
            s2_value_reg <= step_value;
            s2_prev_reg  <= gen_reg.state;
        end
        if (s3_free && s2_valid_reg)
        begin
            s3_value_reg <= s2_value_reg;
            s3_prev_reg  <= s2_prev_reg;
            s3_lz_reg    <= lz_next;
        end
        if (out_free && s3_valid_reg)
        begin
            out_value_reg <= s3_value_reg;
            out_prev_reg  <= s3_prev_reg;
            out_dbl_reg   <= dbl_next;
        end
    end

    // result beat
    assign out_valid      = out_valid_reg;
    assign new_value      = out_value_reg;
    assign previous_state = out_prev_reg;
    assign unsigned_31    = out_value_reg[XW-1:17];
    assign signed_32      = signed'(out_value_reg[XW-1:16]);
    assign fraction_q48   = out_value_reg;
    assign double_bits    = out_dbl_reg;

    // zero maps to zero and only zero
    a_zero_map: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((new_value == '0) == (double_bits == '0)))
        else $error("double pattern disagrees with zero value");

    // exponent range of a nonzero fraction
    a_exp_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && new_value != '0) |->
            (double_bits[62:52] >= 11'd975 && double_bits[62:52] <= EXP_TOP
             && !double_bits[63]))
        else $error("double exponent out of range");

    // generator registers change only as an item leaves the input stage
    a_gen_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_move |=> $stable(gen_reg))
        else $error("generator registers changed without an item");

endmodule
